// ===== src/fcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpt_pkg
// Shared types, constants and helper functions of the framed command parser.
// ----------------------------------------------------------------------------
package fcpt_pkg;

    // longest name or value that a frame may carry, plus one
    localparam int BUFFER_SIZE = 4096;
    localparam int LEN_W       = $clog2(BUFFER_SIZE);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(BUFFER_SIZE - 1);

    localparam logic [LEN_W-1:0] HUD_LEN     = LEN_W'(3);
    localparam logic [LEN_W-1:0] LOGGING_LEN = LEN_W'(7);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // command queue between parser and executor
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_HUD       = 3'd1,
        EV_LOG_START = 3'd2,
        EV_LOG_STOP  = 3'd3,
        EV_UNKNOWN   = 3'd4,
        EV_ABANDON   = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        CMD_NONE     = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_ABANDON  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic      is_hud;
        logic      is_logging;
        logic      nonempty;
        logic      nonzero;
        logic      negative;
    } t_cmd;

    function automatic logic [7:0] hud_ref_char(input logic [LEN_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            LEN_W'(0): ch = 8'h68;
            LEN_W'(1): ch = 8'h75;
            LEN_W'(2): ch = 8'h64;
            default:   ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] logging_ref_char(input logic [LEN_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            LEN_W'(0): ch = 8'h6C;
            LEN_W'(1): ch = 8'h6F;
            LEN_W'(2): ch = 8'h67;
            LEN_W'(3): ch = 8'h67;
            LEN_W'(4): ch = 8'h69;
            LEN_W'(5): ch = 8'h6E;
            LEN_W'(6): ch = 8'h67;
            default:   ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/fcpt_if.sv =====
// ----------------------------------------------------------------------------
// fcpt_in_if / fcpt_out_if
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface fcpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcpt_out_if;
    logic       valid;
    logic       ready;
    logic       hud_hidden;
    logic       logging_on;
    logic [2:0] event_res;

    modport source (output valid, output hud_hidden, output logging_on,
                    output event_res, input ready);
    modport sink   (input valid, input hud_hidden, input logging_on,
                    input event_res, output ready);
endinterface

// ===== src/fcpt_front.sv =====
// ----------------------------------------------------------------------------
// fcpt_front
// Frames the byte stream, matches the name and classifies the value; emits
// one command per accepted byte.
// ----------------------------------------------------------------------------
module fcpt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fcpt_in_if.sink        i_rx,
    input  logic           i_queue_full,
    output logic           o_push,
    output fcpt_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        VP_SKIP   = 2'd0,
        VP_DIGITS = 2'd1,
        VP_DONE   = 2'd2
    } t_phase;

    logic                        r_in_frame,        n_in_frame;
    logic                        r_in_value,        n_in_value;
    logic [fcpt_pkg::LEN_W-1:0]  r_name_length,     n_name_length;
    logic [fcpt_pkg::LEN_W-1:0]  r_value_length,    n_value_length;
    logic                        r_name_is_hud,     n_name_is_hud;
    logic                        r_name_is_logging, n_name_is_logging;
    logic                        r_name_ended,      n_name_ended;
    t_phase                      r_value_phase,     n_value_phase;
    logic                        r_value_negative,  n_value_negative;
    logic                        r_value_nonzero,   n_value_nonzero;
    logic                        r_value_nonempty,  n_value_nonempty;

    logic       accept;
    logic [7:0] c;
    logic       is_digit;
    logic       is_space;

    assign i_rx.ready = !i_queue_full;
    assign accept     = i_rx.valid && !i_queue_full;
    assign o_push     = accept;
    assign c          = i_rx.rx_byte;
    assign is_digit   = (c >= fcpt_pkg::CH_ZERO) && (c <= fcpt_pkg::CH_NINE);
    assign is_space   = (c == fcpt_pkg::CH_SPACE) ||
                        ((c >= fcpt_pkg::CH_TAB) && (c <= fcpt_pkg::CH_CR));

    always_comb begin
        n_in_frame        = r_in_frame;
        n_in_value        = r_in_value;
        n_name_length     = r_name_length;
        n_value_length    = r_value_length;
        n_name_is_hud     = r_name_is_hud;
        n_name_is_logging = r_name_is_logging;
        n_name_ended      = r_name_ended;
        n_value_phase     = r_value_phase;
        n_value_negative  = r_value_negative;
        n_value_nonzero   = r_value_nonzero;
        n_value_nonempty  = r_value_nonempty;

        o_cmd.kind       = fcpt_pkg::CMD_NONE;
        // terminating zero at the current name position
        o_cmd.is_hud     = r_name_is_hud &&
                           (r_name_ended || (r_name_length >= fcpt_pkg::HUD_LEN));
        o_cmd.is_logging = r_name_is_logging &&
                           (r_name_ended || (r_name_length >= fcpt_pkg::LOGGING_LEN));
        o_cmd.nonempty   = r_value_nonempty;
        o_cmd.nonzero    = r_value_nonzero;
        o_cmd.negative   = r_value_negative;

        if (c == fcpt_pkg::CH_COLON) begin
            n_in_frame        = 1'b1;
            n_in_value        = 1'b0;
            n_name_length     = '0;
            n_value_length    = '0;
            n_name_is_hud     = 1'b1;
            n_name_is_logging = 1'b1;
            n_name_ended      = 1'b0;
            n_value_phase     = VP_SKIP;
            n_value_negative  = 1'b0;
            n_value_nonzero   = 1'b0;
            n_value_nonempty  = 1'b0;
        end else if (!r_in_frame) begin
            // outside a frame
        end else if (c == fcpt_pkg::CH_SEMI) begin
            o_cmd.kind = fcpt_pkg::CMD_COMPLETE;
            n_in_frame = 1'b0;
            n_in_value = 1'b0;
        end else if (c == fcpt_pkg::CH_EQUAL) begin
            n_in_value = 1'b1;
        end else if (r_in_value) begin
            if (r_value_length >= fcpt_pkg::LEN_LIMIT) begin
                o_cmd.kind = fcpt_pkg::CMD_ABANDON;
                n_in_frame = 1'b0;
                n_in_value = 1'b0;
            end else begin
                n_value_length = r_value_length + 1'b1;
                if ((r_value_length == '0) && (c != fcpt_pkg::CH_NUL)) begin
                    n_value_nonempty = 1'b1;
                end
                unique case (r_value_phase)
                    VP_SKIP: begin
                        if (is_space) begin
                            n_value_phase = VP_SKIP;
                        end else if (c == fcpt_pkg::CH_PLUS) begin
                            n_value_phase = VP_DIGITS;
                        end else if (c == fcpt_pkg::CH_MINUS) begin
                            n_value_negative = 1'b1;
                            n_value_phase    = VP_DIGITS;
                        end else if (is_digit) begin
                            n_value_phase = VP_DIGITS;
                            if (c != fcpt_pkg::CH_ZERO) n_value_nonzero = 1'b1;
                        end else begin
                            n_value_phase = VP_DONE;
                        end
                    end
                    VP_DIGITS: begin
                        if (is_digit) begin
                            if (c != fcpt_pkg::CH_ZERO) n_value_nonzero = 1'b1;
                        end else begin
                            n_value_phase = VP_DONE;
                        end
                    end
                    default: begin
                        n_value_phase = r_value_phase;
                    end
                endcase
            end
        end else begin
            if (r_name_length >= fcpt_pkg::LEN_LIMIT) begin
                o_cmd.kind = fcpt_pkg::CMD_ABANDON;
                n_in_frame = 1'b0;
            end else begin
                n_name_length = r_name_length + 1'b1;
                if (!r_name_ended) begin
                    if (c != fcpt_pkg::hud_ref_char(r_name_length)) n_name_is_hud = 1'b0;
                    if (c != fcpt_pkg::logging_ref_char(r_name_length)) begin
                        n_name_is_logging = 1'b0;
                    end
                    if (c == fcpt_pkg::CH_NUL) n_name_ended = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame        <= 1'b0;
            r_in_value        <= 1'b0;
            r_name_length     <= '0;
            r_value_length    <= '0;
            r_name_is_hud     <= 1'b1;
            r_name_is_logging <= 1'b1;
            r_name_ended      <= 1'b0;
            r_value_phase     <= VP_SKIP;
            r_value_negative  <= 1'b0;
            r_value_nonzero   <= 1'b0;
            r_value_nonempty  <= 1'b0;
        end else if (accept) begin
            r_in_frame        <= n_in_frame;
            r_in_value        <= n_in_value;
            r_name_length     <= n_name_length;
            r_value_length    <= n_value_length;
            r_name_is_hud     <= n_name_is_hud;
            r_name_is_logging <= n_name_is_logging;
            r_name_ended      <= n_name_ended;
            r_value_phase     <= n_value_phase;
            r_value_negative  <= n_value_negative;
            r_value_nonzero   <= n_value_nonzero;
            r_value_nonempty  <= n_value_nonempty;
        end
    end

endmodule

// ===== src/fcpt_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// fcpt_cmd_queue
// Small register queue that decouples the parser from the executor.
// ----------------------------------------------------------------------------
module fcpt_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fcpt_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output fcpt_pkg::t_cmd o_cmd
);

    fcpt_pkg::t_cmd r_slot [fcpt_pkg::QUEUE_DEPTH];

    logic [fcpt_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [fcpt_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [fcpt_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (fcpt_pkg::QUEUE_AW+1)'(fcpt_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == fcpt_pkg::QUEUE_AW'(fcpt_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == fcpt_pkg::QUEUE_AW'(fcpt_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/fcpt_back.sv =====
// ----------------------------------------------------------------------------
// fcpt_back
// Carries out queued commands on the hidden and logging flags and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module fcpt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  fcpt_pkg::t_cmd i_cmd,
    output logic           o_pop,
    fcpt_out_if.source     o_res
);

    logic              r_hidden_flag,    n_hidden_flag;
    logic              r_logging_active, n_logging_active;
    logic              r_out_valid;
    logic              r_out_hidden;
    logic              r_out_logging;
    fcpt_pkg::t_event  r_out_event,      n_event;

    logic is_zero;
    logic positive;

    assign o_pop = !i_empty && (!r_out_valid || o_res.ready);

    assign o_res.valid      = r_out_valid;
    assign o_res.hud_hidden = r_out_hidden;
    assign o_res.logging_on = r_out_logging;
    assign o_res.event_res  = r_out_event;

    assign is_zero  = !i_cmd.nonzero;
    assign positive = i_cmd.nonzero && !i_cmd.negative;

    always_comb begin
        n_hidden_flag    = r_hidden_flag;
        n_logging_active = r_logging_active;
        n_event          = fcpt_pkg::EV_NONE;
        unique case (i_cmd.kind)
            fcpt_pkg::CMD_COMPLETE: begin
                n_event = fcpt_pkg::EV_UNKNOWN;
                if (i_cmd.is_hud) begin
                    n_hidden_flag = !r_hidden_flag;
                    n_event       = fcpt_pkg::EV_HUD;
                end
                if (i_cmd.is_logging) begin
                    if (i_cmd.nonempty) begin
                        // a request for the state already held does nothing
                        if (is_zero && r_logging_active) begin
                            n_logging_active = 1'b0;
                            n_event          = fcpt_pkg::EV_LOG_STOP;
                        end else if (positive && !r_logging_active) begin
                            n_logging_active = 1'b1;
                            n_event          = fcpt_pkg::EV_LOG_START;
                        end
                    end else begin
                        n_logging_active = !r_logging_active;
                        n_event          = r_logging_active ? fcpt_pkg::EV_LOG_STOP
                                                            : fcpt_pkg::EV_LOG_START;
                    end
                end
            end
            fcpt_pkg::CMD_ABANDON: begin
                n_event = fcpt_pkg::EV_ABANDON;
            end
            default: begin
                n_event = fcpt_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidden_flag    <= 1'b0;
            r_logging_active <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_hidden_flag    <= n_hidden_flag;
                r_logging_active <= n_logging_active;
                r_out_valid      <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_hidden  <= n_hidden_flag;
            r_out_logging <= n_logging_active;
            r_out_event   <= n_event;
        end
    end

endmodule

// ===== src/framed_command_parser_toggle_unit.sv =====
// ----------------------------------------------------------------------------
// framed_command_parser_toggle_unit
// Frames ":name=value;" commands from a byte stream and toggles the overlay
// hidden and logging flags; one result per received byte.
// ----------------------------------------------------------------------------
// path: an accepted byte's command is written into the command queue, then popped
//   into the executor's output register, which holds its result; an output stall keeps it in the queue
// throughput: one byte per cycle while the queue is not full, set by the per-byte parser
//   update and a two-entry command queue ahead of the executor's output register
// reset: synchronous, clears framing state, both flags and the queue; no
//   clearing pass, ready is high once a reset edge has emptied the queue
module framed_command_parser_toggle_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcpt_in_if.sink    i_rx,
    fcpt_out_if.source o_res
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    fcpt_pkg::t_cmd front_cmd;
    fcpt_pkg::t_cmd queue_cmd;

    fcpt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    fcpt_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_cmd   (queue_cmd)
    );

    fcpt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (queue_empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== dv/fcpt_checker.sv =====
// ----------------------------------------------------------------------------
// fcpt_checker
// Watches the byte and result channels of the command parser, tracks framing,
// name matching, value classification and both flags for every request, and
// compares each result with the oldest predicted one.
// ----------------------------------------------------------------------------
module fcpt_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fcpt_in_if    i_rx,
    fcpt_out_if   i_res,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fcpt_pkg::*;

    localparam int MAX_FIELD_LEN = BUFFER_SIZE - 1;
    localparam logic [23:0] HUD_WORD     = 24'h687564;
    localparam logic [55:0] LOGGING_WORD = 56'h6C6F6767696E67;

    typedef enum logic [1:0] {
        VAL_SKIP_WS = 2'd0,
        VAL_DIGITS  = 2'd1,
        VAL_DONE    = 2'd2
    } t_value_phase;

    typedef struct packed {
        logic   hidden;
        logic   logging;
        t_event ev;
    } t_flag_result;

    t_flag_result expected_flags[$];

    logic         in_frame;
    logic         in_value;
    int           name_len;
    int           value_len;
    logic         name_is_hud;
    logic         name_is_logging;
    logic         name_ended;
    t_value_phase value_phase;
    logic         value_negative;
    logic         value_nonzero;
    logic         value_nonempty;
    logic         hidden_flag;
    logic         logging_flag;

    function automatic void clear_command();
        in_value        = 1'b0;
        name_len        = 0;
        value_len       = 0;
        name_is_hud     = 1'b1;
        name_is_logging = 1'b1;
        name_ended      = 1'b0;
        value_phase     = VAL_SKIP_WS;
        value_negative  = 1'b0;
        value_nonzero   = 1'b0;
        value_nonempty  = 1'b0;
    endfunction

    // a zero byte ends the name for matching; later bytes leave the match alone
    function automatic void match_name_char(int pos, logic [7:0] c);
        logic [7:0] hud_c;
        logic [7:0] log_c;
        if (name_ended) return;
        hud_c = (pos < 3) ? HUD_WORD[8*(2-pos) +: 8] : CH_NUL;
        log_c = (pos < 7) ? LOGGING_WORD[8*(6-pos) +: 8] : CH_NUL;
        if (c != hud_c) name_is_hud = 1'b0;
        if (c != log_c) name_is_logging = 1'b0;
        if (c == CH_NUL) name_ended = 1'b1;
    endfunction

    function automatic t_event parse_rx_byte(logic [7:0] c);
        t_event ev;
        logic   digit;
        ev    = EV_NONE;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (c == CH_COLON) begin
            clear_command();
            in_frame = 1'b1;
        end else if (!in_frame) begin
            ev = EV_NONE;
        end else if (c == CH_SEMI) begin
            match_name_char(name_len, CH_NUL);
            ev = EV_UNKNOWN;
            if (name_is_hud) begin
                hidden_flag = !hidden_flag;
                ev = EV_HUD;
            end
            if (name_is_logging) begin
                if (value_nonempty) begin
                    if (!value_nonzero && logging_flag) begin
                        logging_flag = 1'b0;
                        ev = EV_LOG_STOP;
                    end else if (value_nonzero && !value_negative && !logging_flag) begin
                        logging_flag = 1'b1;
                        ev = EV_LOG_START;
                    end
                end else begin
                    logging_flag = !logging_flag;
                    ev = logging_flag ? EV_LOG_START : EV_LOG_STOP;
                end
            end
            in_frame = 1'b0;
            in_value = 1'b0;
        end else if (c == CH_EQUAL) begin
            // a second '=' is dropped, not part of the value
            in_value = 1'b1;
        end else if (in_value) begin
            if (value_len >= MAX_FIELD_LEN) begin
                in_frame = 1'b0;
                in_value = 1'b0;
                ev = EV_ABANDON;
            end else begin
                if (value_len == 0 && c != CH_NUL) value_nonempty = 1'b1;
                case (value_phase)
                    VAL_SKIP_WS: begin
                        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                            value_phase = VAL_SKIP_WS;
                        end else if (c == CH_PLUS) begin
                            value_phase = VAL_DIGITS;
                        end else if (c == CH_MINUS) begin
                            value_negative = 1'b1;
                            value_phase = VAL_DIGITS;
                        end else if (digit) begin
                            value_phase = VAL_DIGITS;
                            if (c != CH_ZERO) value_nonzero = 1'b1;
                        end else begin
                            value_phase = VAL_DONE;
                        end
                    end
                    VAL_DIGITS: begin
                        if (digit) begin
                            if (c != CH_ZERO) value_nonzero = 1'b1;
                        end else begin
                            value_phase = VAL_DONE;
                        end
                    end
                    default: value_phase = VAL_DONE;
                endcase
                value_len++;
            end
        end else begin
            if (name_len >= MAX_FIELD_LEN) begin
                in_frame = 1'b0;
                ev = EV_ABANDON;
            end else begin
                match_name_char(name_len, c);
                name_len++;
            end
        end
        return ev;
    endfunction

    always @(posedge i_clk) begin
        t_flag_result exp_r;
        t_flag_result got_r;
        if (!i_rst_n) begin
            clear_command();
            in_frame     = 1'b0;
            hidden_flag  = 1'b0;
            logging_flag = 1'b0;
            expected_flags.delete();
        end else begin
            // results first, so a result for this very request counts as early
            if (i_res.valid && i_res.ready) begin
                got_r.hidden  = i_res.hud_hidden;
                got_r.logging = i_res.logging_on;
                got_r.ev      = t_event'(i_res.event_res);
                if (expected_flags.size() == 0) begin
                    $display("%0t ns: result with none expected: hidden=%0d logging=%0d event=%0d",
                             $time, got_r.hidden, got_r.logging, got_r.ev);
                    o_fail_count++;
                end else begin
                    exp_r = expected_flags.pop_front();
                    if (got_r.hidden !== exp_r.hidden || got_r.logging !== exp_r.logging ||
                        got_r.ev !== exp_r.ev) begin
                        $display("%0t ns: mismatch: expected hidden=%0d logging=%0d event=%0d, got hidden=%0d logging=%0d event=%0d",
                                 $time, exp_r.hidden, exp_r.logging, exp_r.ev,
                                 got_r.hidden, got_r.logging, got_r.ev);
                        o_fail_count++;
                    end
                end
            end
            if (i_rx.valid && i_rx.ready) begin
                exp_r.ev      = parse_rx_byte(i_rx.rx_byte);
                exp_r.hidden  = hidden_flag;
                exp_r.logging = logging_flag;
                expected_flags.push_back(exp_r);
            end
        end
        o_pending = expected_flags.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives framed commands into the parser: a few fixed byte strings, then
// random commands (good names, near misses, numeric and odd values, restarts,
// noise), with random idle on both channels. Checking is done by fcpt_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcpt_pkg::*;

    localparam int RANDOM_BYTES = 500;
    localparam int CYCLE_LIMIT  = 4_000_000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    int   bytes_sent;
    bit   send_calm;
    bit   recv_calm;

    logic [7:0] cmd_bytes[$];

    fcpt_in_if  rx_ch ();
    fcpt_out_if res_ch ();

    framed_command_parser_toggle_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    fcpt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL framed_command_parser_toggle_unit");
            $finish;
        end
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // any byte that is not a framing character
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_COLON || b == CH_SEMI || b == CH_EQUAL);
        return b;
    endfunction

    function automatic logic [7:0] rand_digit();
        return ($urandom_range(0, 1) == 0) ? CH_ZERO : 8'($urandom_range(8'h31, CH_NINE));
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
    endtask

    task automatic push_byte(logic [7:0] b);
        int gap;
        gap = draw_wait(send_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_command();
        while (cmd_bytes.size() > 0) push_byte(cmd_bytes.pop_front());
    endtask

    // drop valid first so the last request is not taken again
    task automatic wait_drained();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // result side
    initial begin
        int stall;
        int taken;
        taken        = 0;
        recv_calm    = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
            stall = draw_wait(recv_calm);
            @(negedge i_clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            taken++;
        end
    end

    // request side
    initial begin
        int    pick;
        int    random_end;
        string word;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        i_rst_n       = 1'b0;
        send_calm     = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stray bytes outside a frame, then hud, empty logging and zero logging
        cmd_bytes = '{CH_NUL, 8'hFF, CH_SEMI, CH_EQUAL};
        add_text(":hud;");
        add_text(":logging=;");
        add_text(":logging=0;");
        send_command();
        wait_drained();

        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end) begin
            send_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) cmd_bytes.push_back(8'($urandom_range(0, 255)));
            cmd_bytes.push_back(CH_COLON);
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2: add_text("hud");
                3, 4, 5: add_text("logging");
                6: begin
                    word = "hud";
                    if ($urandom_range(0, 1) == 1) word = "logging";
                    add_text(word);
                    cmd_bytes.push_back(CH_NUL);
                    repeat ($urandom_range(0, 3)) cmd_bytes.push_back(plain_byte());
                end
                7: begin
                    // near misses of both names
                    case ($urandom_range(0, 3))
                        0: word = "hu";
                        1: word = "loggin";
                        2: word = "hudd";
                        default: word = "loggings";
                    endcase
                    add_text(word);
                end
                8: repeat ($urandom_range(1, 6)) cmd_bytes.push_back(plain_byte());
                default: word = "";
            endcase
            if ($urandom_range(0, 3) != 0) begin
                cmd_bytes.push_back(CH_EQUAL);
                pick = $urandom_range(0, 5);
                case (pick)
                    0: word = "";
                    1: begin
                        // a zero first byte empties the value
                        cmd_bytes.push_back(CH_NUL);
                        repeat ($urandom_range(0, 2)) cmd_bytes.push_back(rand_digit());
                    end
                    2: repeat ($urandom_range(1, 4)) cmd_bytes.push_back(plain_byte());
                    default: begin
                        repeat ($urandom_range(0, 2)) begin
                            if ($urandom_range(0, 1) == 0) cmd_bytes.push_back(CH_SPACE);
                            else cmd_bytes.push_back(CH_TAB + 8'($urandom_range(0, 4)));
                        end
                        case ($urandom_range(0, 3))
                            0: cmd_bytes.push_back(CH_PLUS);
                            1: cmd_bytes.push_back(CH_MINUS);
                            default: word = "";
                        endcase
                        repeat ($urandom_range(0, 5)) cmd_bytes.push_back(rand_digit());
                        case ($urandom_range(0, 3))
                            0: cmd_bytes.push_back(plain_byte());
                            1: begin
                                cmd_bytes.push_back(CH_EQUAL);
                                cmd_bytes.push_back(rand_digit());
                            end
                            default: word = "";
                        endcase
                    end
                endcase
            end
            // without a semicolon the next colon restarts the frame
            if ($urandom_range(0, 19) < 17) cmd_bytes.push_back(CH_SEMI);
            send_command();
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS framed_command_parser_toggle_unit");
        end else begin
            $display("FAIL framed_command_parser_toggle_unit");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fcpt_pkg.sv
src/fcpt_if.sv
src/fcpt_front.sv
src/fcpt_cmd_queue.sv
src/fcpt_back.sv
src/framed_command_parser_toggle_unit.sv
dv/fcpt_checker.sv
dv/tb_top.sv
